### rtl/core/preemptive_priority_scheduler_defines.svh
// assertion macros for the preemptive priority scheduler
// used by the port checker; needs nothing else
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_DEFINES_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define PPS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define PPS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/pps_pkg.sv
// shared types and constants of the preemptive priority scheduler
// no dependencies
package pps_pkg;

   localparam int TIME_W = 16;
   localparam int WORK_W = 16;
   localparam int PRIO_W = 8;
   localparam int SLOT_W = 4;
   localparam int REQ_W  = 2;

   typedef logic [TIME_W-1:0] time_type;
   typedef logic [WORK_W-1:0] work_type;
   typedef logic [PRIO_W-1:0] prio_type;
   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [REQ_W-1:0]  req_code_type;

   // request codes
   localparam req_code_type REQ_LOAD  = 2'd0;
   localparam req_code_type REQ_TICK  = 2'd1;
   localparam req_code_type REQ_CLEAR = 2'd2;

   localparam time_type TIME_MAX = 16'hFFFF;
   localparam work_type WAIT_MAX = 16'hFFFF;

   // one table row
   typedef struct packed {
      time_type arrival;
      work_type remaining;
      prio_type prio;
      work_type waited;
   } task_entry_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic clear;
      logic tick_start;
      logic idx_clr;
      logic idx_inc;
      logic rd_en;
      logic rd_upd;
      logic finish;
   } pps_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;
      logic idx_last;
      logic out_free;
   } pps_status_type;

endpackage

### rtl/core/pps_ctrl.sv
// sequencer of the scheduler: request decode and the two table passes of a tick
// depends on pps_pkg
module pps_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  pps_pkg::req_code_type req_type,
   input  pps_pkg::pps_status_type status,
   output pps_pkg::pps_cmd_type  cmd
);
   import pps_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SCAN_TAIL,
      ST_UPDATE,
      ST_UPDATE_TAIL,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_type)
                  REQ_LOAD:  cmd.load = 1'b1;
                  REQ_CLEAR: cmd.clear = 1'b1;
                  REQ_TICK: begin
                     cmd.tick_start = 1'b1;
                     cmd.idx_clr    = 1'b1;
                     state_in       = status.empty ? ST_FINISH : ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            cmd.rd_en = 1'b1;
            if (status.idx_last) begin
               cmd.idx_clr = 1'b1;
               state_in    = ST_SCAN_TAIL;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_SCAN_TAIL: state_in = ST_UPDATE;
         ST_UPDATE: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_upd = 1'b1;
            if (status.idx_last) begin
               state_in = ST_UPDATE_TAIL;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_UPDATE_TAIL: state_in = ST_FINISH;
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/pps_dp.sv
// datapath of the scheduler: task table memory, selection, update and result register
// depends on pps_pkg
module pps_dp #(
   parameter int MAX_PROCS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pps_pkg::pps_cmd_type   cmd,
   output pps_pkg::pps_status_type status,
   input  pps_pkg::time_type      req_arrival,
   input  pps_pkg::work_type      req_burst,
   input  pps_pkg::prio_type      req_prio,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_ran_valid,
   output pps_pkg::slot_type      rsp_ran_slot,
   output pps_pkg::time_type      rsp_tick_start,
   output logic                   rsp_finished,
   output pps_pkg::work_type      rsp_wait_total,
   output logic                   rsp_all_done
);
   import pps_pkg::*;

   localparam int IW  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CW  = $clog2(MAX_PROCS + 1);
   localparam int RSW = (IW > SLOT_W) ? IW : SLOT_W;

   // task table
   task_entry_type mem [MAX_PROCS];
   task_entry_type rd_data_ff;
   logic           wr_en;
   logic [IW-1:0]  wr_addr;
   task_entry_type wr_data;

   logic [CW-1:0]  count_ff;
   time_type       clock_ff;
   logic [IW-1:0]  idx_ff;

   logic           rd_vld_ff;
   logic           rd_upd_ff;
   logic [IW-1:0]  rd_slot_ff;

   // selection and tick summary
   logic           found_ff;
   logic [IW-1:0]  pick_ff;
   prio_type       best_prio_ff;
   time_type       best_arr_ff;
   logic           done_ff;
   work_type       wait_out_ff;
   logic           all_done_ff;

   logic           rsp_valid_ff;
   logic           ran_valid_ff;
   slot_type       ran_slot_ff;
   time_type       tick_start_ff;
   logic           finished_ff;
   work_type       wait_total_ff;
   logic           all_done_out_ff;

   logic           ready_now;
   logic           better;
   logic           is_pick;
   work_type       rem_new;
   work_type       wait_new;
   logic           can_load;
   logic [RSW-1:0] pick_ext;

   assign can_load = (count_ff < CW'(MAX_PROCS));
   assign ready_now = (rd_data_ff.remaining != '0) && (rd_data_ff.arrival <= clock_ff);
   assign better = !found_ff || (rd_data_ff.prio < best_prio_ff) ||
                   ((rd_data_ff.prio == best_prio_ff) && (rd_data_ff.arrival < best_arr_ff));
   assign is_pick = found_ff && (rd_slot_ff == pick_ff);
   assign rem_new = is_pick ? (rd_data_ff.remaining - WORK_W'(1)) : rd_data_ff.remaining;

   always_comb begin
      wait_new = rd_data_ff.waited;
      if (!is_pick && (rem_new != '0) && (rd_data_ff.arrival <= clock_ff) &&
          (rd_data_ff.waited != WAIT_MAX)) begin
         wait_new = rd_data_ff.waited + WORK_W'(1);
      end
   end

   // one write port: load in idle, write-back in the update pass
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = rd_slot_ff;
      wr_data = rd_data_ff;
      if (cmd.load && can_load) begin
         wr_en           = 1'b1;
         wr_addr         = count_ff[IW-1:0];
         wr_data.arrival   = req_arrival;
         wr_data.remaining = req_burst;
         wr_data.prio      = req_prio;
         wr_data.waited    = '0;
      end else if (rd_vld_ff && rd_upd_ff) begin
         wr_en             = 1'b1;
         wr_data.remaining = rem_new;
         wr_data.waited    = wait_new;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[idx_ff];
         rd_slot_ff <= idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         clock_ff     <= '0;
         idx_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rd_upd_ff    <= 1'b0;
         found_ff     <= 1'b0;
         done_ff      <= 1'b0;
         all_done_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.rd_en;
         rd_upd_ff <= cmd.rd_upd;

         if (cmd.idx_clr) begin
            idx_ff <= '0;
         end else if (cmd.idx_inc) begin
            idx_ff <= idx_ff + IW'(1);
         end

         if (cmd.clear) begin
            count_ff <= '0;
            clock_ff <= '0;
         end else if (cmd.load && can_load) begin
            count_ff <= count_ff + CW'(1);
         end else if (cmd.finish && (clock_ff != TIME_MAX)) begin
            clock_ff <= clock_ff + TIME_W'(1);
         end

         if (cmd.tick_start) begin
            found_ff    <= 1'b0;
            done_ff     <= 1'b0;
            all_done_ff <= 1'b1;
         end else if (rd_vld_ff && !rd_upd_ff) begin
            if (ready_now && better) begin
               found_ff <= 1'b1;
            end
         end else if (rd_vld_ff && rd_upd_ff) begin
            if (rem_new != '0) begin
               all_done_ff <= 1'b0;
            end
            if (is_pick && (rem_new == '0)) begin
               done_ff <= 1'b1;
            end
         end

         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.tick_start) begin
         pick_ff     <= '0;
         wait_out_ff <= '0;
      end else if (rd_vld_ff && !rd_upd_ff && ready_now && better) begin
         pick_ff      <= rd_slot_ff;
         best_prio_ff <= rd_data_ff.prio;
         best_arr_ff  <= rd_data_ff.arrival;
      end else if (rd_vld_ff && rd_upd_ff && is_pick && (rem_new == '0)) begin
         wait_out_ff <= rd_data_ff.waited;
      end
      if (cmd.finish) begin
         ran_valid_ff    <= found_ff;
         ran_slot_ff     <= found_ff ? pick_ext[SLOT_W-1:0] : '0;
         tick_start_ff   <= clock_ff;
         finished_ff     <= done_ff;
         wait_total_ff   <= wait_out_ff;
         all_done_out_ff <= all_done_ff;
      end
   end

   assign pick_ext = RSW'(pick_ff);

   assign status.empty    = (count_ff == '0);
   assign status.idx_last = (idx_ff == IW'(count_ff - CW'(1)));
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ran_valid  = ran_valid_ff;
   assign rsp_ran_slot   = ran_slot_ff;
   assign rsp_tick_start = tick_start_ff;
   assign rsp_finished   = finished_ff;
   assign rsp_wait_total = wait_total_ff;
   assign rsp_all_done   = all_done_out_ff;

endmodule

### rtl/core/preemptive_priority_scheduler.sv
// channel   | handshake           | payload
// ----------+---------------------+------------------------------------------------
// request   | req_valid/req_ready | req_type, req_arrival, req_burst, req_prio
// response  | rsp_valid/rsp_ready | rsp_ran_valid, rsp_ran_slot, rsp_tick_start,
//           |                     | rsp_finished, rsp_wait_total, rsp_all_done
//
// load, clear and unused request beats give no response
// a tick beat reads one table row per cycle in the selection pass and again in the update
// pass, through the single read port of the task table
// an empty table skips both passes: the tick goes straight to the finish state
// reset clears the task count, the clock and the handshakes; the table needs no clear
// a response waiting on rsp_ready holds the next tick in its last cycle; idle loads go in
module preemptive_priority_scheduler #(
   parameter int MAX_PROCS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  pps_pkg::req_code_type req_type,
   input  pps_pkg::time_type     req_arrival,
   input  pps_pkg::work_type     req_burst,
   input  pps_pkg::prio_type     req_prio,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_ran_valid,
   output pps_pkg::slot_type     rsp_ran_slot,
   output pps_pkg::time_type     rsp_tick_start,
   output logic                  rsp_finished,
   output pps_pkg::work_type     rsp_wait_total,
   output logic                  rsp_all_done
);
   import pps_pkg::*;

   // command and status between sequencer and datapath
   pps_cmd_type    cmd;
   pps_status_type status;

   // request decode and pass sequencing
   pps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .status    (status),
      .cmd       (cmd)
   );

   // task table, priority pick, wait counting, response register
   pps_dp #(
      .MAX_PROCS (MAX_PROCS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_arrival    (req_arrival),
      .req_burst      (req_burst),
      .req_prio       (req_prio),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_ran_valid  (rsp_ran_valid),
      .rsp_ran_slot   (rsp_ran_slot),
      .rsp_tick_start (rsp_tick_start),
      .rsp_finished   (rsp_finished),
      .rsp_wait_total (rsp_wait_total),
      .rsp_all_done   (rsp_all_done)
   );

endmodule

### rtl/core/pps_checker.sv
// port-level checks of the scheduler, bound to the top level
// depends on pps_pkg and preemptive_priority_scheduler_defines.svh
`include "preemptive_priority_scheduler_defines.svh"

module pps_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  rsp_ran_valid,
   input pps_pkg::slot_type     rsp_ran_slot,
   input pps_pkg::time_type     rsp_tick_start,
   input logic                  rsp_finished,
   input pps_pkg::work_type     rsp_wait_total,
   input logic                  rsp_all_done
);
   import pps_pkg::*;

   // a stalled response beat stays up
   `PPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid,
      "response dropped while stalled")

   // a stalled response keeps its whole payload
   `PPS_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready,
      $stable({rsp_ran_valid, rsp_ran_slot, rsp_tick_start, rsp_finished, rsp_wait_total, rsp_all_done}),
      "response payload changed while stalled")

   // an idle tick reports no slot, no finish and no wait
   `PPS_ASSERT_SAME(a_idle_clean, clock, reset, rsp_valid && !rsp_ran_valid,
      (rsp_ran_slot == '0) && !rsp_finished && (rsp_wait_total == '0),
      "idle tick carries task fields")

   // a response without a finish reports zero wait
   `PPS_ASSERT_SAME(a_finish_ran, clock, reset, rsp_valid && !rsp_finished,
      rsp_wait_total == '0, "wait reported for unfinished task")

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (.*);
